>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the button debouncer.
// Depends on clk and rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, off while reset is asserted.
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication: when a holds, b holds.
`define CHK_IMPLY(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

`endif

>>> sv/mbdhd_pkg.sv
// Types and constants for the multi-button debouncer with hold detection.
// No dependencies; used by the top level.
package mbdhd_pkg;

    localparam int BTN_W      = 32;
    localparam int TIME_W     = 32;
    localparam int HIST_W     = 4;   // low nibble of the history, high nibble always ones
    localparam int INTERVAL_W = 8;
    localparam int TIMEOUT_W  = 16;
    localparam int HOLD_IDX_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_BUTTON    = 2'd2;

    localparam logic [INTERVAL_W-1:0] RESET_CHECK_INTERVAL = 8'd5;
    localparam logic [TIMEOUT_W-1:0]  RESET_HOLD_TIMEOUT   = 16'd1500;

    localparam logic [HIST_W-1:0] HIST_RELEASED = 4'h0;
    localparam logic [HIST_W-1:0] HIST_PRESSED  = 4'hF;

    typedef struct packed {
        logic [BTN_W-1:0]  raw_pins;
        logic [TIME_W-1:0] now_ms;
        logic              menu_shown;
        logic              resume_all;
    } scan_t;

    typedef struct packed {
        logic              scanned;
        logic [BTN_W-1:0]  pressed_state;
        logic [BTN_W-1:0]  changed_mask;
        logic [BTN_W-1:0]  dispatched_mask;
        logic              hold_event;
        logic              processing_on;
    } result_t;

endpackage

>>> sv/multi_button_debounce_hold_detect.sv
// Top level of the multi-button debouncer with long-hold detection.
// Depends on mbdhd_pkg and assert_macros.svh.
//
// One scan request goes in, one result comes out. A scan is first captured in
// an input register; from there a single pass of combinational logic
// debounces all buttons, works out the change, dispatch and re-enable masks,
// runs the hold timer and loads the result register together with all state.
// A new scan is taken every cycle as long as the result side keeps up: the
// input register only stalls when a result is waiting and the consumer
// stalls it.
// A scan is processed only when now_ms - last processed scan time (mod 2^32)
// exceeds check_interval_ms; otherwise the result reports scanned = 0 and the
// current state, and only resume_all takes effect. Each button keeps a 4-bit
// level history (the constant high nibble of the 8-bit form is implied); all
// ones or all zeros is a stable level. Buttons are treated as if handled in
// ascending index order: a change seen while processing is on re-enables every
// disabled released button, judged against the pressed word as updated so far.
// The watched button is timed while pressed and enabled; a hold longer than
// hold_timeout_ms with no menu shown disables it and turns processing off.
// Configuration writes are always ready and should only be issued while idle.
`include "assert_macros.svh"

module multi_button_debounce_hold_detect #(
    parameter int NUM_BUTTONS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // scan channel
    input  logic                            scan_valid,
    output logic                            scan_stall,
    input  mbdhd_pkg::scan_t                scan,
    // result channel
    output logic                            res_valid,
    input  logic                            res_stall,
    output mbdhd_pkg::result_t              res,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mbdhd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbdhd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int BW = mbdhd_pkg::BTN_W;
    // buttons that exist; the rest are never scanned
    localparam logic [BW-1:0] BTN_MASK = BW'((64'd1 << NUM_BUTTONS) - 64'd1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [mbdhd_pkg::INTERVAL_W-1:0] interval_reg;
    logic [mbdhd_pkg::TIMEOUT_W-1:0]  timeout_reg;
    logic [mbdhd_pkg::HOLD_IDX_W-1:0] hold_idx_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= mbdhd_pkg::RESET_CHECK_INTERVAL;
            timeout_reg  <= mbdhd_pkg::RESET_HOLD_TIMEOUT;
            hold_idx_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mbdhd_pkg::CFG_CHECK_INTERVAL:
                    interval_reg <= cfg_data[mbdhd_pkg::INTERVAL_W-1:0];
                mbdhd_pkg::CFG_HOLD_TIMEOUT:
                    timeout_reg <= cfg_data[mbdhd_pkg::TIMEOUT_W-1:0];
                mbdhd_pkg::CFG_HOLD_BUTTON:
                    hold_idx_reg <= cfg_data[mbdhd_pkg::HOLD_IDX_W-1:0];
                default:
                begin
                    // unknown register: write dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register and handshake
    // ------------------------------------------------------------------
    mbdhd_pkg::scan_t   scan_reg;
    logic               scan_vld_reg;
    mbdhd_pkg::result_t res_reg;
    logic               res_vld_reg;
    logic               advance;

    // one pass per cycle: fire when a scan is held and the result slot frees
    assign advance    = scan_vld_reg && (!res_vld_reg || !res_stall);
    assign scan_stall = scan_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_vld_reg <= 1'b0;
        end
        else if (!scan_stall)
        begin
            scan_vld_reg <= scan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && !scan_stall)
        begin
            scan_reg <= scan;
        end
    end

    // ------------------------------------------------------------------
    // debounce state
    // ------------------------------------------------------------------
    logic [mbdhd_pkg::HIST_W-1:0] hist_reg  [NUM_BUTTONS];
    logic [mbdhd_pkg::HIST_W-1:0] hist_next [NUM_BUTTONS];
    logic [BW-1:0]                pressed_reg, pressed_next;
    logic [BW-1:0]                enable_reg, enable_next;
    logic                         proc_reg, proc_next;
    logic [mbdhd_pkg::TIME_W-1:0] hold_start_reg, hold_start_next;
    logic [mbdhd_pkg::TIME_W-1:0] last_scan_reg, last_scan_next;

    // ------------------------------------------------------------------
    // single-pass scan logic
    // ------------------------------------------------------------------
    logic [mbdhd_pkg::TIME_W-1:0] since_last, held_for;
    logic                         do_scan;
    logic                         proc_eff;
    logic [BW-1:0]                level;      // 1 = pressed
    logic [BW-1:0]                stable;
    logic [BW-1:0]                changed;
    logic [BW-1:0]                dispatched;
    logic [BW-1:0]                chg_below;  // some change at a lower index
    logic [BW-1:0]                chg_at_up;  // some change at this index or above
    logic [BW-1:0]                sweep_en;
    logic [BW-1:0]                enable_swept;
    logic [BW-1:0]                hold_bit;
    logic                         hold_active;
    logic                         hold_fire;

    always_comb
    begin
        since_last = scan_reg.now_ms - last_scan_reg;
        held_for   = scan_reg.now_ms - hold_start_reg;
        do_scan    = since_last > mbdhd_pkg::TIME_W'(interval_reg);
        proc_eff   = proc_reg || scan_reg.resume_all;
        level      = ~scan_reg.raw_pins & BTN_MASK;

        stable = '0;
        for (int k = 0; k < NUM_BUTTONS; k++)
        begin
            hist_next[k] = {hist_reg[k][mbdhd_pkg::HIST_W-2:0], level[k]};
            stable[k]    = (hist_next[k] == mbdhd_pkg::HIST_RELEASED)
                        || (hist_next[k] == mbdhd_pkg::HIST_PRESSED);
        end

        changed      = do_scan ? (stable & (level ^ pressed_reg) & BTN_MASK) : '0;
        pressed_next = pressed_reg ^ changed;

        // prefix flags of the in-order walk over the buttons
        for (int j = 0; j < BW; j++)
        begin
            chg_below[j] = 1'b0;
            chg_at_up[j] = 1'b0;
            for (int i = 0; i < BW; i++)
            begin
                if (i < j)
                    chg_below[j] = chg_below[j] | changed[i];
                else
                    chg_at_up[j] = chg_at_up[j] | changed[i];
            end
        end

        // a button is already re-enabled when its turn comes if an earlier
        // change swept it while its pressed bit still held the old value
        dispatched = proc_eff
                   ? (changed & (enable_reg | (chg_below & ~pressed_reg))) : '0;
        // sweeps at or after a button see its new level, before it the old one
        sweep_en     = proc_eff
                     ? ((chg_at_up & ~pressed_next) | (chg_below & ~pressed_reg)) : '0;
        enable_swept = enable_reg | sweep_en;

        hold_bit    = BW'(1) << hold_idx_reg;
        hold_active = |(hold_bit & pressed_next & enable_swept);
        hold_fire   = do_scan && hold_active && (hold_start_reg != '0)
                   && (held_for > mbdhd_pkg::TIME_W'(timeout_reg))
                   && !scan_reg.menu_shown;

        enable_next     = enable_swept;
        proc_next       = proc_eff;
        hold_start_next = hold_start_reg;
        if (do_scan)
        begin
            if (!hold_active || hold_fire)
                hold_start_next = '0;
            else if (hold_start_reg == '0)
                hold_start_next = scan_reg.now_ms;
            if (hold_fire)
            begin
                enable_next = enable_swept & ~hold_bit;
                proc_next   = 1'b0;
            end
        end
        last_scan_next = do_scan ? scan_reg.now_ms : last_scan_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_BUTTONS; k++)
                hist_reg[k] <= mbdhd_pkg::HIST_RELEASED;
            pressed_reg    <= '0;
            enable_reg     <= '1;
            proc_reg       <= 1'b1;
            hold_start_reg <= '0;
            last_scan_reg  <= '0;
        end
        else if (advance)
        begin
            if (do_scan)
            begin
                for (int k = 0; k < NUM_BUTTONS; k++)
                    hist_reg[k] <= hist_next[k];
            end
            pressed_reg    <= pressed_next;
            enable_reg     <= enable_next;
            proc_reg       <= proc_next;
            hold_start_reg <= hold_start_next;
            last_scan_reg  <= last_scan_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_vld_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.scanned         <= do_scan;
            res_reg.pressed_state   <= pressed_next;
            res_reg.changed_mask    <= changed;
            res_reg.dispatched_mask <= dispatched;
            res_reg.hold_event      <= hold_fire;
            res_reg.processing_on   <= proc_next;
        end
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CHK_IMPLY(a_chg_needs_scan, res_valid && (res.changed_mask != '0), res.scanned,
        "change reported on a scan that was not processed")
    `CHK_PROP(a_disp_in_chg, !res_valid || ((res.dispatched_mask & ~res.changed_mask) == '0),
        "dispatched button without a change")
    `CHK_IMPLY(a_hold_stops_proc, res_valid && res.hold_event, !res.processing_on,
        "hold event left processing on")
    `CHK_IMPLY(a_disp_needs_proc, res_valid && (res.dispatched_mask != '0),
        res.processing_on || res.hold_event, "dispatch while processing was off")

endmodule

>>> dv/tb_multi_button_debounce_hold_detect.sv
// Self-checking testbench for multi_button_debounce_hold_detect.
// Depends on mbdhd_pkg and the RTL top level. A built-in scan predictor checks
// every result under random idling and stalls on both channels.
module tb_multi_button_debounce_hold_detect;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BTN_W      = mbdhd_pkg::BTN_W;
    localparam int TIME_W     = mbdhd_pkg::TIME_W;
    localparam int INTERVAL_W = mbdhd_pkg::INTERVAL_W;
    localparam int TIMEOUT_W  = mbdhd_pkg::TIMEOUT_W;
    localparam int HOLD_IDX_W = mbdhd_pkg::HOLD_IDX_W;
    localparam int CFG_IDX_W  = mbdhd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mbdhd_pkg::CFG_DATA_W;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_SCANS   = 200;
    localparam int SHOW_LIMIT    = 10;

    // index 3 is past the end of the register map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // 8-bit history marks: stable released / stable pressed
    localparam logic [7:0]  HIST_LOW_MARK  = 8'hF0;
    localparam logic [7:0]  HIST_HIGH_MARK = 8'hFF;
    localparam logic [31:0] ALL_RELEASED   = 32'hFFFF_FFFF;  // pins are active low

    bit                     clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   scan_valid = 1'b0;
    logic                   scan_stall;
    mbdhd_pkg::scan_t       scan       = '0;
    logic                   res_valid;
    logic                   res_stall  = 1'b0;
    mbdhd_pkg::result_t     res;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    multi_button_debounce_hold_detect dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan       (scan),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the debouncer and its registers.
    // ------------------------------------------------------------------
    logic [7:0]             level_hist [BTN_W];
    logic [BTN_W-1:0]       pressed_w;
    logic [BTN_W-1:0]       enable_w;
    logic                   proc_on;
    logic [TIME_W-1:0]      hold_t0;        // 0 means the timer is idle
    logic [TIME_W-1:0]      last_scan_t;
    logic [INTERVAL_W-1:0]  interval_r;
    logic [TIMEOUT_W-1:0]   timeout_r;
    logic [HOLD_IDX_W-1:0]  watch_r;

    // predicted results, oldest first
    mbdhd_pkg::result_t     scan_results_due [$];

    bit                     quiet_mode = 1'b0;  // no idling on either side
    logic [TIME_W-1:0]      clock_ms   = '0;    // scan time carried between tests
    int                     cycle_count     = 0;
    int                     mismatch_count  = 0;
    int                     results_checked = 0;
    int                     scans_sent      = 0;
    int                     scans_taken     = 0;
    int                     holds_fired     = 0;
    int                     changes_seen    = 0;
    int                     dispatches_seen = 0;

    function automatic void reset_debouncer_model();
        int k;
        for (k = 0; k < BTN_W; k++)
            level_hist[k] = HIST_LOW_MARK;
        pressed_w   = '0;
        enable_w    = '1;
        proc_on     = 1'b1;
        hold_t0     = '0;
        last_scan_t = '0;
        interval_r  = mbdhd_pkg::RESET_CHECK_INTERVAL;
        timeout_r   = mbdhd_pkg::RESET_HOLD_TIMEOUT;
        watch_r     = '0;
    endfunction

    // Register values are truncated to the register width; unknown indexes are dropped.
    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        case (idx)
            mbdhd_pkg::CFG_CHECK_INTERVAL: interval_r = data[INTERVAL_W-1:0];
            mbdhd_pkg::CFG_HOLD_TIMEOUT:   timeout_r  = data[TIMEOUT_W-1:0];
            mbdhd_pkg::CFG_HOLD_BUTTON:    watch_r    = data[HOLD_IDX_W-1:0];
            default: ;
        endcase
    endfunction

    // One scan through the debouncer: updates the predictor state and returns
    // the result the block should report for it.
    function automatic mbdhd_pkg::result_t debounce_scan(input mbdhd_pkg::scan_t s);
        mbdhd_pkg::result_t r;
        logic [7:0]         h;
        logic               lvl;
        int                 k;
        r = '0;
        // resume counts even when the interval gate drops the scan
        if (s.resume_all)
            proc_on = 1'b1;
        if (32'(s.now_ms - last_scan_t) > 32'(interval_r)) begin
            r.scanned = 1'b1;
            for (k = 0; k < BTN_W; k++) begin
                lvl = ~s.raw_pins[k];
                h = {level_hist[k][6:0], lvl} | HIST_LOW_MARK;
                level_hist[k] = h;
                if ((h == HIST_LOW_MARK || h == HIST_HIGH_MARK) && pressed_w[k] != lvl) begin
                    pressed_w[k] = lvl;
                    r.changed_mask[k] = 1'b1;
                    if (proc_on) begin
                        if (enable_w[k])
                            r.dispatched_mask[k] = 1'b1;
                        // re-enable released buttons, seen through the pressed
                        // word as updated so far (higher buttons not yet scanned)
                        enable_w = enable_w | ~pressed_w;
                    end
                end
            end
            if (pressed_w[watch_r] && enable_w[watch_r]) begin
                if (hold_t0 == '0) begin
                    hold_t0 = s.now_ms;
                end
                else if (32'(s.now_ms - hold_t0) > 32'(timeout_r) && !s.menu_shown) begin
                    enable_w[watch_r] = 1'b0;
                    hold_t0           = '0;
                    proc_on           = 1'b0;
                    r.hold_event      = 1'b1;
                end
            end
            else begin
                hold_t0 = '0;
            end
            last_scan_t = s.now_ms;
        end
        r.pressed_state = pressed_w;
        r.processing_on = proc_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks. All are entered and left on a rising clock edge.
    // ------------------------------------------------------------------

    // Sends one scan request. Valid stays high on return so back-to-back
    // requests never lower and raise it within one step.
    task automatic send_scan(input logic [BTN_W-1:0] pins, input logic [TIME_W-1:0] t,
                             input logic menu, input logic resume);
        mbdhd_pkg::scan_t   s;
        mbdhd_pkg::result_t want;
        int                 gap;
        s.raw_pins   = pins;
        s.now_ms     = t;
        s.menu_shown = menu;
        s.resume_all = resume;
        gap = 0;
        if (!quiet_mode)
            while ($urandom_range(0, 99) < 20)
                gap++;
        if (gap > 0) begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan       <= s;
        scan_valid <= 1'b1;
        @(posedge clk);
        while (scan_stall)
            @(posedge clk);
        want = debounce_scan(s);
        scan_results_due.push_back(want);
        scans_sent++;
        scans_taken     += want.scanned;
        holds_fired     += want.hold_event;
        changes_seen    += $countones(want.changed_mask);
        dispatches_seen += $countones(want.dispatched_mask);
    endtask

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg_write(idx, data);
    endtask

    // Writes all three registers with junk in the bits above each register width.
    task automatic set_config(input logic [INTERVAL_W-1:0] ival,
                              input logic [TIMEOUT_W-1:0] tmo,
                              input logic [HOLD_IDX_W-1:0] widx);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(mbdhd_pkg::CFG_CHECK_INTERVAL, {junk[CFG_DATA_W-1:INTERVAL_W], ival});
        write_reg(mbdhd_pkg::CFG_HOLD_TIMEOUT, tmo);
        write_reg(mbdhd_pkg::CFG_HOLD_BUTTON, {junk[CFG_DATA_W-HOLD_IDX_W-1:0], widx});
        cfg_valid <= 1'b0;
    endtask

    // Sender holds off until every predicted result is back, then lets the
    // two-stage pipeline settle before anything else happens.
    task automatic wait_results_drained();
        scan_valid <= 1'b0;
        while (scan_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
                $display("[%0t] result %0d: %s expected %h, got %h",
                         $realtime, results_checked, fname, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, and a check of every accepted result.
    // ------------------------------------------------------------------
    always @(posedge clk)
        res_stall <= !quiet_mode && ($urandom_range(0, 99) < 20);

    always @(posedge clk) begin
        mbdhd_pkg::result_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (scan_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("[%0t] result with no scan request pending: %p", $realtime, res);
            end
            else begin
                want = scan_results_due.pop_front();
                check_field("scanned", 32'(want.scanned), 32'(res.scanned));
                check_field("pressed_state", want.pressed_state, res.pressed_state);
                check_field("changed_mask", want.changed_mask, res.changed_mask);
                check_field("dispatched_mask", want.dispatched_mask, res.dispatched_mask);
                check_field("hold_event", 32'(want.hold_event), 32'(res.hold_event));
                check_field("processing_on", 32'(want.processing_on), 32'(res.processing_on));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("watchdog expired after %0d cycles, %0d results still due",
                 cycle_count, scan_results_due.size());
        $display("tb_multi_button_debounce_hold_detect: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed tests (reset register values: interval 5, timeout 1500,
    // watched button 0).
    // ------------------------------------------------------------------

    // Interval gate at and below the limit, then a press of every button
    // with one bouncy scan that has to restart the history.
    task automatic test_gating_and_debounce();
        int i;
        send_scan(ALL_RELEASED, 32'd3, 1'b0, 1'b0);     // too early
        send_scan(ALL_RELEASED, 32'd5, 1'b0, 1'b0);     // elapsed == interval, dropped
        send_scan(32'h0, 32'd6, 1'b0, 1'b0);            // first pressed sample
        send_scan(ALL_RELEASED, 32'd12, 1'b0, 1'b0);    // bounce
        for (i = 0; i < 4; i++)
            send_scan(32'h0, 32'd18 + 6 * i, 1'b0, 1'b0);   // stable at t=36, timer starts
        clock_ms = 32'd36;
    endtask

    // Long hold blocked by the menu, then fired; releases while processing is
    // off; resume on a dropped scan; a new press re-enables the held button.
    task automatic test_hold_and_resume();
        int i;
        send_scan(32'h0, 32'd1636, 1'b1, 1'b0);         // past timeout, menu up
        send_scan(32'h0, 32'd1700, 1'b0, 1'b0);         // hold fires
        for (i = 0; i < 4; i++)
            send_scan(ALL_RELEASED, 32'd1706 + 6 * i, 1'b0, 1'b0);
        send_scan(ALL_RELEASED, 32'd1725, 1'b0, 1'b1);  // dropped scan, resume still counts
        for (i = 0; i < 4; i++)
            send_scan(~32'h2, 32'd1731 + 6 * i, 1'b0, 1'b0);
        clock_ms = 32'd1749;
    endtask

    // Write to the unused index, truncated register data, zero interval and
    // timeout on the top button across the time wrap, so that the press
    // settles exactly at now_ms == 0. Then the largest interval and timeout.
    task automatic test_register_extremes();
        int i;
        wait_results_drained();
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(mbdhd_pkg::CFG_CHECK_INTERVAL, 16'hFF00);   // truncates to 0
        write_reg(mbdhd_pkg::CFG_HOLD_BUTTON, 16'hFFFF);      // truncates to 31
        write_reg(mbdhd_pkg::CFG_HOLD_TIMEOUT, 16'h0000);
        cfg_valid <= 1'b0;
        for (i = 0; i < 4; i++)
            send_scan(32'h7FFF_FFFF, 32'hFFFF_FFFD + i, 1'b0, 1'b0);
        send_scan(32'h7FFF_FFFF, 32'd0, 1'b0, 1'b0);    // same time, dropped
        send_scan(32'h7FFF_FFFF, 32'd1, 1'b0, 1'b0);    // timer really starts here
        send_scan(32'h7FFF_FFFF, 32'd2, 1'b0, 1'b0);    // fires
        wait_results_drained();
        set_config(8'd255, 16'hFFFF, 5'd31);
        send_scan(32'h7FFF_FFFF, 32'd257, 1'b0, 1'b0);  // elapsed 255, dropped
        send_scan(32'h7FFF_FFFF, 32'd258, 1'b0, 1'b1);
        clock_ms = 32'd258;
    endtask

    // ------------------------------------------------------------------
    // Random traffic: a few "busy" buttons (the watched one among them) are
    // pressed and released for long stretches, with single-scan glitches,
    // whole-word noise, early scans, long gaps and time jumps mixed in.
    // Each phase runs with fresh registers; one phase runs without idling.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        logic [TIME_W-1:0]     now_t;
        logic [BTN_W-1:0]      pins_lv;
        logic [BTN_W-1:0]      pins;
        logic [HOLD_IDX_W-1:0] busy_btn [4];
        logic [INTERVAL_W-1:0] ival;
        logic [TIMEOUT_W-1:0]  tmo;
        logic [HOLD_IDX_W-1:0] widx;
        int                    phase;
        int                    n;
        int                    i;
        int                    pick;
        now_t   = clock_ms;
        pins_lv = ALL_RELEASED;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results_drained();
            case ($urandom_range(0, 3))
                0:       ival = '0;
                1:       ival = '1;
                default: ival = INTERVAL_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 3))
                0:       tmo = '0;
                1:       tmo = '1;
                default: tmo = TIMEOUT_W'($urandom_range(1, 400));
            endcase
            widx = HOLD_IDX_W'($urandom_range(0, BTN_W - 1));
            set_config(ival, tmo, widx);
            busy_btn[0] = widx;
            for (i = 1; i < 4; i++)
                busy_btn[i] = HOLD_IDX_W'($urandom_range(0, BTN_W - 1));
            quiet_mode = (phase == 2);
            for (n = 0; n < PHASE_SCANS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    pins_lv[busy_btn[$urandom_range(0, 3)]] ^= 1'b1;
                else if (pick < 10)
                    pins_lv[$urandom_range(0, BTN_W - 1)] ^= 1'b1;
                pins = pins_lv;
                if (pick >= 10 && pick < 20)
                    pins[$urandom_range(0, BTN_W - 1)] ^= 1'b1;   // one-scan glitch
                else if (pick >= 20 && pick < 24)
                    pins = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    now_t += $urandom_range(0, ival);             // inside the interval
                else if (pick < 20)
                    now_t += tmo + $urandom_range(0, 300);        // long gap, hold territory
                else if (pick < 23)
                    now_t = $urandom;                             // arbitrary jump
                else
                    now_t += ival + 1 + $urandom_range(0, 7);
                send_scan(pins, now_t, $urandom_range(0, 99) < 10,
                          $urandom_range(0, 99) < 5);
            end
        end
        quiet_mode = 1'b0;
        clock_ms   = now_t;
    endtask

    initial begin
        reset_debouncer_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_gating_and_debounce();
        test_hold_and_resume();
        test_register_extremes();
        test_random_traffic();
        wait_results_drained();
        $display("Sent %0d scan requests, %0d passed the interval gate, %0d results checked",
                 scans_sent, scans_taken, results_checked);
        $display("Debounced changes %0d, dispatched %0d, long holds fired %0d",
                 changes_seen, dispatches_seen, holds_fired);
        if (mismatch_count == 0 && scan_results_due.size() == 0)
            $display("tb_multi_button_debounce_hold_detect: PASS");
        else
            $display("tb_multi_button_debounce_hold_detect: FAIL");
        $finish;
    end

endmodule
